FILE: hdl/bpc_pkg.sv
// Shared constants, codes and the sequencer state type for the barometric
// sensor compensation block. No dependencies.
`default_nettype none

package bpc_pkg;

    // Field and register widths.
    localparam int RAW_W      = 24;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int DT_W       = 25;
    localparam int TEMP_W     = 19;
    localparam int PRES_W     = 32;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 56;

    // Shared multiplier: signed operands, registered product.
    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    // Internal accumulator widths.
    localparam int OFF_W = 42;
    localparam int T2_W  = 17;
    localparam int ACC_W = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_C1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C5 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C6 = 3'd5;

    // Input selector and result kind codes.
    localparam logic FUNC_TEMP = 1'b0;
    localparam logic FUNC_PRES = 1'b1;
    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_PRES = 1'b1;

    // Temperature thresholds in hundredths of a degree.
    localparam logic signed [TEMP_W-1:0] T_REF  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] T_VLOW = -19'sd1500;

    // Sequencer states, one-hot.
    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_T_MUL = 17'h00002,
        S_T_FIN = 17'h00004,
        S_P_OFF = 17'h00008,
        S_P_SNS = 17'h00010,
        S_P_DT2 = 17'h00020,
        S_P_A   = 17'h00040,
        S_P_B   = 17'h00080,
        S_P_C   = 17'h00100,
        S_P_SC  = 17'h00200,
        S_P_ABS = 17'h00400,
        S_P_MLO = 17'h00800,
        S_P_MHI = 17'h01000,
        S_P_ACC = 17'h02000,
        S_P_NEG = 17'h04000,
        S_P_SUB = 17'h08000,
        S_DONE  = 17'h10000
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/baro_temp_pressure_compensation.sv
// Barometric sensor compensation: first-order temperature, offset and
// sensitivity, second-order low-temperature correction and pressure.
// Depends on bpc_pkg and bpc_mul.
//
// Usage:
// Input beats carry a raw 24-bit conversion in tdata and the conversion kind
// in tuser (0 temperature, 1 pressure). Output beats carry the temperature in
// hundredths of a degree and the pressure in pascals in tdata, and the result
// kind in tuser. Every input beat produces exactly one output beat.
// Calibration words are written through the plain write port; the user must
// do so only while idle, as the block itself does not enforce it. All
// arithmetic runs through one registered 26x26 multiplier stepped by a
// one-hot sequencer. A temperature beat passes through one multiply and a
// finish step, a pressure beat through eight multiplies plus the sign,
// accumulate, offset and finish steps, before its result is loaded.
// The block takes one beat at a time: tready is high only in the idle state.
// A finished result sits in the output register; the block accepts the next
// beat while it waits, and holds its new result back until the register
// frees up, so a stalled receiver loses nothing.
// Reset (synchronous, active low) clears the calibration words, the kept
// temperature difference and temperature, and the output valid flag.
`default_nettype none

module baro_temp_pressure_compensation (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [bpc_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // tdata: raw_value[23:0]
    input  wire logic [bpc_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // tuser: func[0]
    input  wire logic                                i_s_axis_tuser,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // tdata: temperature_centi[18:0], pressure_pa[50:19], zero pad[55:51]
    output logic [bpc_pkg::OUT_DATA_W-1:0]           o_m_axis_tdata,
    // tuser: result_kind[0]
    output logic                                     o_m_axis_tuser
);
    import bpc_pkg::*;

    // Calibration words.
    logic [CFG_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    // Sequencer and datapath registers.
    t_state                    r_state, n_state;
    logic                      r_func, n_func;
    logic [RAW_W-1:0]          r_raw, n_raw;
    logic signed [DT_W-1:0]    r_dt, n_dt;
    logic signed [TEMP_W-1:0]  r_temp, n_temp;
    logic signed [OFF_W-1:0]   r_off, n_off;
    logic signed [OFF_W-1:0]   r_sens, n_sens;
    logic                      r_neg, n_neg;
    logic [T2_W-1:0]           r_t2, n_t2;
    logic [ACC_W-1:0]          r_acc, n_acc;
    logic signed [PRES_W-1:0]  r_p, n_p;
    logic                      r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data, n_out_data;
    logic                      r_out_kind, n_out_kind;

    // Multiplier operands and product.
    logic signed [MUL_W-1:0]   w_op_a, w_op_b;
    logic signed [PROD_W-1:0]  w_prod;

    // Helper values.
    logic                      w_accept;
    logic                      w_slot;
    logic                      w_low;
    logic                      w_vlow;
    logic signed [MUL_W-1:0]   w_dt_ext;
    logic signed [21:0]        w_d22;
    logic signed [21:0]        w_d5;
    logic signed [22:0]        w_e23;
    logic signed [22:0]        w_e7;
    logic signed [22:0]        w_e11;
    logic [PROD_W-1:0]         w_rnd7, w_rnd8, w_rnd23;
    logic signed [20:0]        w_t1;
    logic signed [20:0]        w_tc;
    logic [ACC_W-1:0]          w_mag;
    logic [ACC_W-1:0]          w_rnd15;
    logic signed [48:0]        w_q;
    logic signed [PRES_W-1:0]  w_pclamp;

    // Saturate a widened temperature to the 19-bit signed range.
    function automatic logic signed [TEMP_W-1:0] clamp_temp(input logic signed [20:0] v);
        logic signed [TEMP_W-1:0] res;
        if (v > 21'sd262143) begin
            res = 19'sd262143;
        end else if (v < -21'sd262144) begin
            res = -19'sd262144;
        end else begin
            res = v[TEMP_W-1:0];
        end
        return res;
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_C1:  r_c1 <= i_cfg_data;
                CFG_C2:  r_c2 <= i_cfg_data;
                CFG_C3:  r_c3 <= i_cfg_data;
                CFG_C4:  r_c4 <= i_cfg_data;
                CFG_C5:  r_c5 <= i_cfg_data;
                CFG_C6:  r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and comparisons on the kept temperature.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot          = !r_out_valid || i_m_axis_tready;
    assign w_low           = (r_temp < T_REF);
    assign w_vlow          = (r_temp < T_VLOW);

    // Operand preparation: dT, 5*(T-2000), 7*(T+1500) and 11*(T+1500).
    assign w_dt_ext = {r_dt[DT_W-1], r_dt};
    assign w_d22    = {{3{r_temp[TEMP_W-1]}}, r_temp} - 22'sd2000;
    assign w_d5     = (w_d22 <<< 2) + w_d22;
    assign w_e23    = {{4{r_temp[TEMP_W-1]}}, r_temp} + 23'sd1500;
    assign w_e7     = (w_e23 <<< 3) - w_e23;
    assign w_e11    = (w_e23 <<< 3) + (w_e23 <<< 1) + w_e23;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        unique case (r_state)
            S_T_MUL: begin
                w_op_a = w_dt_ext;
                w_op_b = $signed({10'd0, r_c6});
            end
            S_P_OFF: begin
                w_op_a = w_dt_ext;
                w_op_b = $signed({10'd0, r_c4});
            end
            S_P_SNS: begin
                w_op_a = w_dt_ext;
                w_op_b = $signed({10'd0, r_c3});
            end
            S_P_DT2: begin
                w_op_a = w_dt_ext;
                w_op_b = w_dt_ext;
            end
            S_P_A: begin
                w_op_a = {{4{w_d5[21]}}, w_d5};
                w_op_b = {{4{w_d22[21]}}, w_d22};
            end
            S_P_B: begin
                w_op_a = {{3{w_e7[22]}}, w_e7};
                w_op_b = {{3{w_e23[22]}}, w_e23};
            end
            S_P_C: begin
                w_op_a = {{3{w_e11[22]}}, w_e11};
                w_op_b = {{3{w_e23[22]}}, w_e23};
            end
            S_P_MLO: begin
                w_op_a = $signed({2'b00, r_sens[23:0]});
                w_op_b = $signed({2'b00, r_raw});
            end
            S_P_MHI: begin
                w_op_a = $signed({9'd0, r_sens[40:24]});
                w_op_b = $signed({2'b00, r_raw});
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    bpc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_op_a),
        .i_b   (w_op_b),
        .o_p   (w_prod)
    );

    // Truncating power-of-two divisions: bias negative values before the shift.
    assign w_rnd7  = w_prod + {45'd0, {7{w_prod[PROD_W-1]}}};
    assign w_rnd8  = w_prod + {44'd0, {8{w_prod[PROD_W-1]}}};
    assign w_rnd23 = w_prod + {29'd0, {23{w_prod[PROD_W-1]}}};
    assign w_t1    = $signed({w_rnd23[42], w_rnd23[42:23]}) + 21'sd2000;
    assign w_tc    = {{2{r_temp[TEMP_W-1]}}, r_temp} - {4'd0, r_t2};
    assign w_mag   = {21'd0, r_acc[ACC_W-1:21]};
    assign w_rnd15 = r_acc + {49'd0, {15{r_acc[ACC_W-1]}}};
    assign w_q     = $signed(w_rnd15[ACC_W-1:15]);

    // Pressure saturation to 32 bits.
    always_comb begin
        if (w_q > 49'sd2147483647) begin
            w_pclamp = 32'sh7FFFFFFF;
        end else if (w_q < -49'sd2147483648) begin
            w_pclamp = 32'sh80000000;
        end else begin
            w_pclamp = w_q[PRES_W-1:0];
        end
    end

    // Sequencer: most states consume the product of the state before and issue the next operands.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_raw       = r_raw;
        n_dt        = r_dt;
        n_temp      = r_temp;
        n_off       = r_off;
        n_sens      = r_sens;
        n_neg       = r_neg;
        n_t2        = r_t2;
        n_acc       = r_acc;
        n_p         = r_p;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_func = i_s_axis_tuser;
                    n_raw  = i_s_axis_tdata;
                    if (i_s_axis_tuser == FUNC_TEMP) begin
                        n_dt    = $signed({1'b0, i_s_axis_tdata}) - $signed({1'b0, r_c5, 8'd0});
                        n_state = S_T_MUL;
                    end else begin
                        n_state = S_P_OFF;
                    end
                end
            end
            S_T_MUL: n_state = S_T_FIN;
            S_T_FIN: begin
                n_temp  = clamp_temp(w_t1);
                n_p     = '0;
                n_state = S_DONE;
            end
            S_P_OFF: n_state = S_P_SNS;
            S_P_SNS: begin
                n_off   = $signed({10'd0, r_c2, 16'd0}) + $signed(w_rnd7[48:7]);
                n_state = S_P_DT2;
            end
            S_P_DT2: begin
                n_sens  = $signed({11'd0, r_c1, 15'd0}) + $signed(w_rnd8[49:8]);
                n_state = S_P_A;
            end
            S_P_A: begin
                n_t2    = w_low ? w_prod[47:31] : '0;
                n_state = S_P_B;
            end
            S_P_B: begin
                // Second-order correction terms 5A/2 and 5A/4.
                if (w_low) begin
                    n_off  = r_off - $signed({1'b0, w_prod[41:1]});
                    n_sens = r_sens - $signed({2'b00, w_prod[41:2]});
                end
                n_state = S_P_C;
            end
            S_P_C: begin
                // Extra offset term 7B at very low temperature.
                if (w_vlow) begin
                    n_off = r_off - $signed(w_prod[41:0]);
                end
                n_state = S_P_SC;
            end
            S_P_SC: begin
                // Extra sensitivity term 11B/2, then the corrected temperature.
                if (w_vlow) begin
                    n_sens = r_sens - $signed({1'b0, w_prod[41:1]});
                end
                n_temp  = clamp_temp(w_tc);
                n_state = S_P_ABS;
            end
            S_P_ABS: begin
                n_neg   = r_sens[OFF_W-1];
                n_sens  = r_sens[OFF_W-1] ? (42'sd0 - r_sens) : r_sens;
                n_state = S_P_MLO;
            end
            S_P_MLO: n_state = S_P_MHI;
            S_P_MHI: begin
                n_acc   = {16'd0, w_prod[47:0]};
                n_state = S_P_ACC;
            end
            S_P_ACC: begin
                n_acc   = r_acc + {w_prod[39:0], 24'd0};
                n_state = S_P_NEG;
            end
            S_P_NEG: begin
                n_acc   = r_neg ? (64'd0 - w_mag) : w_mag;
                n_state = S_P_SUB;
            end
            S_P_SUB: begin
                n_acc   = r_acc - {{22{r_off[OFF_W-1]}}, r_off};
                n_state = S_DONE;
            end
            S_DONE: begin
                // Pressure saturates here for pressure beats; temperature beats
                // already cleared it.
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_func;
                    if (r_func == FUNC_PRES) begin
                        n_p        = w_pclamp;
                        n_out_data = {5'd0, w_pclamp, r_temp};
                    end else begin
                        n_out_data = {5'd0, r_p, r_temp};
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and kept sensor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dt        <= '0;
            r_temp      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_dt        <= n_dt;
            r_temp      <= n_temp;
        end
    end

    // Datapath payload registers.
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_raw      <= n_raw;
        r_off      <= n_off;
        r_sens     <= n_sens;
        r_neg      <= n_neg;
        r_t2       <= n_t2;
        r_acc      <= n_acc;
        r_p        <= n_p;
        r_out_data <= n_out_data;
        r_out_kind <= n_out_kind;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;

    // An accepted beat keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // A pressure beat never disturbs the kept temperature difference.
    a_dt_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_axis_tuser == FUNC_PRES) |=> $stable(r_dt))
        else $error("pressure beat changed the temperature difference");

    // Temperature results carry a zero pressure field.
    a_temp_zero_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_TEMP) |-> (r_out_data[50:19] == '0))
        else $error("temperature result with nonzero pressure");

    // A finished result with a free output slot is presented next cycle.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_slot) |=> r_out_valid)
        else $error("finished result not loaded into the output register");

endmodule

`default_nettype wire

FILE: hdl/bpc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bpc_pkg for the operand width.
`default_nettype none

module bpc_mul (
    input  wire logic                               i_clk,
    input  wire logic signed [bpc_pkg::MUL_W-1:0]  i_a,
    input  wire logic signed [bpc_pkg::MUL_W-1:0]  i_b,
    output logic signed [bpc_pkg::PROD_W-1:0]       o_p
);
    import bpc_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: tb/baro_temp_pressure_compensation_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for baro_temp_pressure_compensation: a stream driver,
// a stream monitor and an integer predictor of the compensation arithmetic.
// Depends on bpc_pkg and the RTL of the block.

module baro_temp_pressure_compensation_tb;

    import bpc_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_STALL   = 300;
    localparam int QUIET_CYCLES = 25;
    localparam int PRINT_CAP    = 100;

    localparam longint TEMP_LO = -64'sd262144;
    localparam longint TEMP_HI = 64'sd262143;
    localparam longint PRES_LO = -64'sd2147483648;
    localparam longint PRES_HI = 64'sd2147483647;
    localparam longint RAW_MAX = 64'sd16777215;

    // Indexes outside the register map; writes to them change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        bit              func;
        bit [RAW_W-1:0]  raw;
    } t_conversion;

    typedef struct {
        bit              kind;
        bit [TEMP_W-1:0] temp;
        bit [PRES_W-1:0] pres;
    } t_comp_result;

    // Clock, reset and block ports.
    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_W-1:0]      i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_s_axis_tuser  = 1'b0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;

    // Predictor copy of the calibration words and the kept state.
    bit [CFG_W-1:0] cal [6] = '{default: '0};
    longint         kept_dt   = 0;
    longint         kept_temp = 0;

    t_conversion  pending_conversions [$];
    t_comp_result expected_results [$];
    t_conversion  next_conv;
    t_comp_result want;

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    bit  in_beat_taken  = 1'b0;
    bit  idle_on        = 1'b0;
    int  src_gap        = 0;
    int  rx_gap         = 0;
    int  rx_hold        = 0;
    int  stall_req      = 0;
    int  stall_seen     = 0;

    baro_temp_pressure_compensation DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Uniform random raw conversion and calibration word.
    function automatic bit [RAW_W-1:0] rand_raw();
        return RAW_W'($urandom());
    endfunction

    function automatic bit [CFG_W-1:0] rand_cal();
        return CFG_W'($urandom());
    endfunction

    // Signed shift right by sh that rounds toward zero.
    function automatic longint trunc_shift(input longint x, input int sh);
        if (x < 0) begin
            return -((-x) >>> sh);
        end
        return x >>> sh;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Expected result of one conversion beat; updates the kept dT and TEMP.
    function automatic t_comp_result compensate(input bit func, input bit [RAW_W-1:0] raw);
        t_comp_result r;
        longint c1 = longint'(cal[CFG_C1]);
        longint c2 = longint'(cal[CFG_C2]);
        longint c3 = longint'(cal[CFG_C3]);
        longint c4 = longint'(cal[CFG_C4]);
        longint c5 = longint'(cal[CFG_C5]);
        longint c6 = longint'(cal[CFG_C6]);
        longint raw_l = longint'(raw);
        longint dt, t, off, sens, t2, off2, sens2, a, b, scaled, p;
        bit [63:0] sens_mag;
        bit [63:0] raw_u = 64'(raw);
        if (func == FUNC_TEMP) begin
            dt = raw_l - (c5 <<< 8);
            t = longint'(T_REF) + trunc_shift(dt * c6, 23);
            kept_dt = dt;
            kept_temp = clip(t, TEMP_LO, TEMP_HI);
            r.kind = KIND_TEMP;
            r.temp = kept_temp[TEMP_W-1:0];
            r.pres = '0;
            return r;
        end
        dt = kept_dt;
        t = kept_temp;
        off = (c2 <<< 16) + trunc_shift(c4 * dt, 7);
        sens = (c1 <<< 15) + trunc_shift(c3 * dt, 8);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        // Second-order terms below 20.00 C, with more below -15.00 C.
        if (t < T_REF) begin
            a = (t - T_REF) * (t - T_REF);
            t2 = (dt * dt) >>> 31;
            off2 = (5 * a) / 2;
            sens2 = (5 * a) / 4;
            if (t < T_VLOW) begin
                b = (t - T_VLOW) * (t - T_VLOW);
                off2 += 7 * b;
                sens2 += (11 * b) / 2;
            end
        end
        t = clip(t - t2, TEMP_LO, TEMP_HI);
        kept_temp = t;
        off -= off2;
        sens -= sens2;
        // The product is formed on the magnitude so the shift truncates toward zero.
        if (sens < 0) begin
            sens_mag = -sens;
            scaled = -longint'((sens_mag * raw_u) >> 21);
        end else begin
            sens_mag = sens;
            scaled = longint'((sens_mag * raw_u) >> 21);
        end
        p = clip(trunc_shift(scaled - off, 15), PRES_LO, PRES_HI);
        r.kind = KIND_PRES;
        r.temp = t[TEMP_W-1:0];
        r.pres = p[PRES_W-1:0];
        return r;
    endfunction

    // Raw temperature conversion that lands at or just below a target TEMP.
    function automatic bit [RAW_W-1:0] raw_for_temp(input longint target);
        longint c6 = longint'(cal[CFG_C6]);
        longint dt, raw;
        if (c6 == 0) begin
            return rand_raw();
        end
        dt = ((target - longint'(T_REF)) <<< 23) / c6;
        if (target < T_REF) begin
            dt -= 1;
        end
        raw = clip((longint'(cal[CFG_C5]) <<< 8) + dt, 0, RAW_MAX);
        return raw[RAW_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        end
        mismatch_count++;
    endtask

    // One register write; the predictor copy follows at once since the block is idle.
    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx <= CFG_C6) begin
            cal[idx] = val;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_cal(input logic [CFG_W-1:0] v1, input logic [CFG_W-1:0] v2,
                           input logic [CFG_W-1:0] v3, input logic [CFG_W-1:0] v4,
                           input logic [CFG_W-1:0] v5, input logic [CFG_W-1:0] v6);
        write_cal(CFG_C1, v1);
        write_cal(CFG_C2, v2);
        write_cal(CFG_C3, v3);
        write_cal(CFG_C4, v4);
        write_cal(CFG_C5, v5);
        write_cal(CFG_C6, v6);
    endtask

    task automatic push_conv(input bit func, input bit [RAW_W-1:0] raw);
        pending_conversions.push_back('{func: func, raw: raw});
    endtask

    // Waits until every beat is taken and every result is back, then lets the
    // pipeline settle before the next register write.
    task automatic wait_for_quiet();
        while (pending_conversions.size() != 0 || i_s_axis_tvalid ||
               expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Random traffic: mostly a temperature beat followed by pressure beats,
    // with lone temperature and lone pressure beats mixed in.
    task automatic gen_traffic(input int n);
        int count;
        int shape;
        int reps;
        longint near;
        longint target;
        bit [RAW_W-1:0] traw;
        bit [RAW_W-1:0] praw;
        count = 0;
        while (count < n) begin
            shape = $urandom_range(0, 9);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: traw = rand_raw();
                5, 6, 7: begin
                    near = (longint'(cal[CFG_C5]) <<< 8)
                         + longint'($urandom_range(0, 8191)) - 4096;
                    near = clip(near, 0, RAW_MAX);
                    traw = near[RAW_W-1:0];
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: target = longint'(T_REF);
                        1: target = longint'(T_REF) - 1;
                        2: target = longint'(T_VLOW);
                        3: target = longint'(T_VLOW) - 1;
                        default: target = longint'($urandom_range(0, 60000)) - 30000;
                    endcase
                    traw = raw_for_temp(target);
                end
            endcase
            if (shape <= 7) begin
                push_conv(FUNC_TEMP, traw);
                count++;
            end
            if (shape != 7) begin
                reps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
                repeat (reps) begin
                    praw = rand_raw();
                    if ($urandom_range(0, 15) == 0) begin
                        praw = $urandom_range(0, 1) ? '1 : '0;
                    end
                    push_conv(FUNC_PRES, praw);
                    count++;
                end
            end
        end
    endtask

    // Stimulus sequence and final verdict.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Pressure before any temperature, with the calibration still at reset.
        push_conv(FUNC_PRES, '1);
        wait_for_quiet();

        // Typical calibration: both correction regions and repeated correction.
        set_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        push_conv(FUNC_PRES, '0);
        push_conv(FUNC_PRES, '1);
        push_conv(FUNC_TEMP, raw_for_temp(longint'(T_REF)));
        push_conv(FUNC_PRES, '1);
        push_conv(FUNC_PRES, '0);
        push_conv(FUNC_TEMP, raw_for_temp(longint'(T_REF) - 1));
        push_conv(FUNC_PRES, rand_raw());
        push_conv(FUNC_TEMP, raw_for_temp(longint'(T_VLOW)));
        push_conv(FUNC_PRES, rand_raw());
        push_conv(FUNC_TEMP, raw_for_temp(longint'(T_VLOW) - 1));
        push_conv(FUNC_PRES, rand_raw());
        push_conv(FUNC_TEMP, '0);
        push_conv(FUNC_PRES, '1);
        push_conv(FUNC_PRES, '0);
        push_conv(FUNC_PRES, rand_raw());
        push_conv(FUNC_TEMP, '1);
        push_conv(FUNC_PRES, '1);
        push_conv(FUNC_PRES, '0);
        wait_for_quiet();

        // All words at maximum: deep cold drives the kept temperature into saturation.
        set_cal('1, '1, '1, '1, '1, '1);
        push_conv(FUNC_TEMP, '0);
        repeat (4) push_conv(FUNC_PRES, '1);
        push_conv(FUNC_TEMP, '1);
        push_conv(FUNC_PRES, '0);
        wait_for_quiet();

        idle_on = 1'b1;
        set_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal(), rand_cal(), rand_cal());
        gen_traffic(300);
        wait_for_quiet();

        // Long receiver stall while the sender keeps offering beats.
        set_cal(rand_cal(), rand_cal(), rand_cal(), rand_cal(), rand_cal(), rand_cal());
        stall_req = stall_req + 1;
        gen_traffic(250);
        wait_for_quiet();

        set_cal('1, '1, '1, '1, '1, '1);
        gen_traffic(100);
        wait_for_quiet();

        // All words cleared, plus writes to the spare indexes.
        set_cal('0, '0, '0, '0, '0, '0);
        write_cal(CFG_SPARE_LO, rand_cal());
        write_cal(CFG_SPARE_HI, rand_cal());
        gen_traffic(60);
        wait_for_quiet();

        // Last part runs without idling on either side.
        idle_on = 1'b0;
        set_cal(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
        gen_traffic(350);
        wait_for_quiet();

        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Input driver: holds a beat until it is taken, then offers the next one.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else if (i_s_axis_tvalid && !in_beat_taken) begin
            // Beat still waiting for the block.
        end else if (src_gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap <= src_gap - 1;
        end else if (pending_conversions.size() == 0) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            src_gap <= $urandom_range(0, 5);
        end else begin
            next_conv = pending_conversions.pop_front();
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= next_conv.raw;
            i_s_axis_tuser  <= next_conv.func;
        end
    end

    // Result receiver: random ready bursts and one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_seen != stall_req) begin
            stall_seen <= stall_req;
            rx_hold <= LONG_STALL;
            i_m_axis_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(0, 5);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Monitor: checks result beats against the oldest expectation and
    // predicts every accepted input beat.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (!i_rst_n) begin
            in_beat_taken <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_axis_tuser !== want.kind) begin
                        report_mismatch($sformatf("kind got %b want %b",
                                                  o_m_axis_tuser, want.kind));
                    end
                    if (o_m_axis_tdata[TEMP_W-1:0] !== want.temp) begin
                        report_mismatch($sformatf("temperature got %0d want %0d",
                                        $signed(o_m_axis_tdata[TEMP_W-1:0]),
                                        $signed(want.temp)));
                    end
                    if (o_m_axis_tdata[TEMP_W +: PRES_W] !== want.pres) begin
                        report_mismatch($sformatf("pressure got %0d want %0d",
                                        $signed(o_m_axis_tdata[TEMP_W +: PRES_W]),
                                        $signed(want.pres)));
                    end
                    if (o_m_axis_tdata[OUT_DATA_W-1:TEMP_W+PRES_W] !== '0) begin
                        report_mismatch($sformatf("pad bits got %b",
                                        o_m_axis_tdata[OUT_DATA_W-1:TEMP_W+PRES_W]));
                    end
                end
            end
            in_beat_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(compensate(i_s_axis_tuser, i_s_axis_tdata));
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

FILE: files.f
hdl/bpc_pkg.sv
hdl/bpc_mul.sv
hdl/baro_temp_pressure_compensation.sv
tb/baro_temp_pressure_compensation_tb.sv
